// ----- rtl/recursive_mutex_wait_queue_top_assert.svh -----
// Assertion macros for the recursive mutex wait queue top level.
// Depends on nothing; included by the top level only.
`ifndef RECURSIVE_MUTEX_WAIT_QUEUE_TOP_ASSERT_SVH
`define RECURSIVE_MUTEX_WAIT_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMWQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmwq_pkg.sv -----
// Shared constants, status codes and interface types of the recursive mutex.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package rmwq_pkg;

    localparam int MAX_THREADS = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_BITS  = 8;

    localparam int ID_W     = 6;
    localparam int STATUS_W = 4;
    localparam int THREAD_BITS = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED         = 4'd0,
        ST_NESTED          = 4'd1,
        ST_BLOCKED         = 4'd2,
        ST_REL_NESTED      = 4'd3,
        ST_RELEASED        = 4'd4,
        ST_NOT_HOLDER      = 4'd5,
        ST_ALREADY_WAITING = 4'd6,
        ST_QUEUE_FULL      = 4'd7,
        ST_OVERFLOW        = 4'd8
    } t_status;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
        logic out_pop;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/rmwq_ctrl.sv -----
// Controller of the recursive mutex: accepts a request, then runs it once
// the output register is free. Depends on rmwq_pkg.
`default_nettype none

module rmwq_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_out_ready,
    input  wire rmwq_pkg::t_dp_status i_status,
    output rmwq_pkg::t_cmd           o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_out_free;

    assign w_out_free = !i_status.out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.out_pop = i_status.out_valid && i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rmwq_dp.sv -----
// Datapath of the recursive mutex: lock state, waiter bitmap, wait queue
// memory and the result register. Depends on rmwq_pkg.
`default_nettype none

module rmwq_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire rmwq_pkg::t_cmd               i_cmd,
    output rmwq_pkg::t_dp_status              o_status_bus,
    input  wire logic                         i_action,
    input  wire logic [rmwq_pkg::ID_W-1:0]    i_thread_id,
    output logic                              o_out_valid,
    output logic [rmwq_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_woken_valid,
    output logic [rmwq_pkg::ID_W-1:0]         o_woken_thread
);

    localparam int TB = rmwq_pkg::THREAD_BITS;
    localparam int QP = rmwq_pkg::QPTR_W;
    localparam int QC = rmwq_pkg::QCNT_W;
    localparam int CB = rmwq_pkg::COUNT_BITS;

    logic                          r_action;
    logic [TB-1:0]                 r_tid;
    logic                          r_holder_valid;
    logic [TB-1:0]                 r_holder_thread;
    logic [CB-1:0]                 r_nest;
    logic                          r_sem_free;
    logic [QP-1:0]                 r_head;
    logic [QC-1:0]                 r_count;
    logic [rmwq_pkg::MAX_THREADS-1:0] r_map;
    logic [TB-1:0]                 r_fifo [rmwq_pkg::QUEUE_DEPTH];
    logic [TB-1:0]                 r_rd_data;
    logic                          r_out_valid;
    rmwq_pkg::t_status             r_status;
    logic                          r_woken_valid;
    logic [rmwq_pkg::ID_W-1:0]     r_woken_thread;

    logic                          n_holder_valid;
    logic [TB-1:0]                 n_holder_thread;
    logic [CB-1:0]                 n_nest;
    logic                          n_sem_free;
    logic [QP-1:0]                 n_head;
    logic [QC-1:0]                 n_count;
    logic [rmwq_pkg::MAX_THREADS-1:0] n_map;
    rmwq_pkg::t_status             n_status;
    logic                          n_woken_valid;
    logic [rmwq_pkg::ID_W-1:0]     n_woken_thread;

    logic                          w_is_holder;
    logic                          w_push;
    logic [QP:0]                   w_tail_sum;
    logic [QP-1:0]                 w_tail;

    assign w_is_holder = r_holder_valid && (r_holder_thread == r_tid);
    assign w_tail_sum  = {1'b0, r_head} + (QP+1)'(r_count);
    assign w_tail      = (w_tail_sum >= (QP+1)'(rmwq_pkg::QUEUE_DEPTH))
                       ? QP'(w_tail_sum - (QP+1)'(rmwq_pkg::QUEUE_DEPTH))
                       : QP'(w_tail_sum);

    always_comb begin
        n_holder_valid  = r_holder_valid;
        n_holder_thread = r_holder_thread;
        n_nest          = r_nest;
        n_sem_free      = r_sem_free;
        n_head          = r_head;
        n_count         = r_count;
        n_map           = r_map;
        n_woken_valid   = 1'b0;
        n_woken_thread  = '0;
        w_push          = 1'b0;
        n_status        = rmwq_pkg::ST_RELEASED;
        if (r_action == rmwq_pkg::ACT_ACQUIRE) begin
            if (w_is_holder) begin
                if (r_nest == {CB{1'b1}}) begin
                    n_status = rmwq_pkg::ST_OVERFLOW;
                end else begin
                    n_nest   = r_nest + CB'(1);
                    n_status = rmwq_pkg::ST_NESTED;
                end
            end else if (r_map[r_tid]) begin
                n_status = rmwq_pkg::ST_ALREADY_WAITING;
            end else if (r_sem_free) begin
                n_sem_free      = 1'b0;
                n_holder_valid  = 1'b1;
                n_holder_thread = r_tid;
                n_nest          = CB'(1);
                n_status        = rmwq_pkg::ST_GRANTED;
            end else if (r_count >= QC'(rmwq_pkg::QUEUE_DEPTH)) begin
                n_status = rmwq_pkg::ST_QUEUE_FULL;
            end else begin
                w_push       = 1'b1;
                n_count      = r_count + QC'(1);
                n_map[r_tid] = 1'b1;
                n_status     = rmwq_pkg::ST_BLOCKED;
            end
        end else begin
            if (!w_is_holder) begin
                n_status = rmwq_pkg::ST_NOT_HOLDER;
            end else if (r_nest > CB'(1)) begin
                n_nest   = r_nest - CB'(1);
                n_status = rmwq_pkg::ST_REL_NESTED;
            end else begin
                n_holder_valid  = 1'b0;
                n_holder_thread = '0;
                n_nest          = '0;
                n_sem_free      = 1'b1;
                n_status        = rmwq_pkg::ST_RELEASED;
                if (r_count != '0) begin
                    n_woken_valid      = 1'b1;
                    n_woken_thread     = rmwq_pkg::ID_W'(r_rd_data);
                    n_head             = (r_head == QP'(rmwq_pkg::QUEUE_DEPTH - 1))
                                       ? '0 : r_head + QP'(1);
                    n_count            = r_count - QC'(1);
                    n_map[r_rd_data]   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_push) begin
            r_fifo[w_tail] <= r_tid;
        end
        r_rd_data <= r_fifo[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_tid    <= TB'(i_thread_id);
        end
        if (i_cmd.exec) begin
            r_status       <= n_status;
            r_woken_valid  <= n_woken_valid;
            r_woken_thread <= n_woken_thread;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holder_valid  <= 1'b0;
            r_holder_thread <= '0;
            r_nest          <= '0;
            r_sem_free      <= 1'b1;
            r_head          <= '0;
            r_count         <= '0;
            r_map           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_holder_valid  <= n_holder_valid;
                r_holder_thread <= n_holder_thread;
                r_nest          <= n_nest;
                r_sem_free      <= n_sem_free;
                r_head          <= n_head;
                r_count         <= n_count;
                r_map           <= n_map;
                r_out_valid     <= 1'b1;
            end else if (i_cmd.out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status_bus.out_valid = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_woken_valid  = r_woken_valid;
    assign o_woken_thread = r_woken_thread;

endmodule

`default_nettype wire

// ----- rtl/recursive_mutex_wait_queue_top.sv -----
// Recursive mutex with a FIFO wait queue. Each request transfer (acquire or
// release from a thread id) yields exactly one result transfer with a status,
// and on a final release the oldest waiter is reported as woken. A request
// is first taken in while the head of the wait queue memory is read; then,
// once the result register is free, the lock state is updated and the result
// register is loaded. A new request is taken while a result still waits, but
// not while one is in work. Reset clears the lock state, queue pointers,
// waiter bitmap and result valid flag at once; there is no clearing pass.
// Depends on rmwq_pkg, rmwq_ctrl, rmwq_dp and the assertion macro header.
`default_nettype none

`include "recursive_mutex_wait_queue_top_assert.svh"

module recursive_mutex_wait_queue_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_action,
    input  wire logic [rmwq_pkg::ID_W-1:0]    i_thread_id,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [rmwq_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_woken_valid,
    output logic [rmwq_pkg::ID_W-1:0]         o_woken_thread
);

    rmwq_pkg::t_cmd       w_cmd;
    rmwq_pkg::t_dp_status w_status;

    rmwq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rmwq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status_bus   (w_status),
        .i_action       (i_action),
        .i_thread_id    (i_thread_id),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_woken_valid  (o_woken_valid),
        .o_woken_thread (o_woken_thread)
    );

    `RMWQ_ASSERT_SAME(a_woken_on_release, i_clk, i_rst_n,
        o_out_valid && o_woken_valid,
        o_status == rmwq_pkg::ST_RELEASED, "woken thread without a final release")
    `RMWQ_ASSERT_SAME(a_woken_zero, i_clk, i_rst_n,
        o_out_valid && !o_woken_valid,
        o_woken_thread == '0, "woken thread id set without a woken flag")
    `RMWQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "request taken while one is in work")
    `RMWQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n,
        !o_in_ready && (!o_out_valid || i_out_ready), o_out_valid && o_in_ready,
        "request in work did not produce a result")

endmodule

`default_nettype wire
